// ===== design/mbm_pkg.sv =====
// ----------------------------------------------------------------------------
// mbm_pkg
// Shared codes for the memory bank mapper: access modes, targets and
// configuration register indexes.
// ----------------------------------------------------------------------------
package mbm_pkg;

  // access modes carried in the input tuser
  typedef enum logic [1:0] {
    MODE_ACCESS = 2'd0,
    MODE_BANK   = 2'd1,
    MODE_COL80  = 2'd2,
    MODE_UNUSED = 2'd3
  } mode_t;

  // physical targets carried in the output tuser
  typedef enum logic [2:0] {
    TGT_EMPTY = 3'd0,
    TGT_ROM   = 3'd1,
    TGT_CART  = 3'd2,
    TGT_RAM   = 3'd3,
    TGT_COL80 = 3'd4
  } target_t;

  // configuration register indexes
  localparam logic [1:0] REG_RAM_KIB       = 2'd0;
  localparam logic [1:0] REG_CART_PRESENT  = 2'd1;
  localparam logic [1:0] REG_COL80_PRESENT = 2'd2;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 9;
  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = 24;
  localparam int unsigned PhysW    = 18;

  localparam logic [8:0] RAM_KIB_RESET = 9'd64;
  localparam logic [7:0] BANK_RESET    = 8'hFF;

endpackage

// ===== design/memory_bank_mapper_top.sv =====
// ----------------------------------------------------------------------------
// memory_bank_mapper_top
// Decodes one CPU memory access per transfer onto empty space, system ROM,
// cartridge ROM, main RAM or the 80-column card RAM, with bank-select and
// card-enable port writes handled in line.
// ----------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  s_*       in         s_tvalid/s_tready  tuser mode, tdata address/is_write/value
//  m_*       out        m_tvalid/m_tready  tuser target, tdata phys_addr/flags
//  cfg_*     in         cfg_valid/cfg_ready cfg_index, cfg_data
//
//  one item per cycle sustained while m_tready stays high: an input register
//  feeds the decode and a result register holds its outcome. the result
//  register stalls on m_tready low and the input register then fills, after
//  which s_tready drops. reset clears both valid bits and the card enable, sets
//  bank_select to 0xff and ram_kib to 64, and clears the two presence bits.
//  cfg_ready is always high.
// ----------------------------------------------------------------------------
module memory_bank_mapper_top (
  input  logic                          clk,
  input  logic                          rst,
  // slave stream
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // [15:0] address, [16] is_write, [24:17] value
  input  logic [mbm_pkg::InDataW-1:0]   s_tdata,
  // [1:0] mode
  input  logic [1:0]                    s_tuser,
  // master stream
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // [17:0] phys_addr, [18] write_allowed, [19] ext_io_enabled, [20] caps_led_on
  output logic [mbm_pkg::OutDataW-1:0]  m_tdata,
  // [2:0] target
  output logic [2:0]                    m_tuser,
  // configuration writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mbm_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [mbm_pkg::CfgDataW-1:0]  cfg_data
);
  import mbm_pkg::*;

  typedef enum logic [1:0] {
    SEL_INT  = 2'd0,
    SEL_CART = 2'd1,
    SEL_EXP2 = 2'd2,
    SEL_EXP3 = 2'd3
  } bank_sel_t;

  // configuration
  logic [8:0] ram_kib;
  logic       cart_present;
  logic       col80_present;

  // mapper state
  logic [7:0] bank_select, bank_select_next;
  logic       col80_ram_on, col80_ram_on_next;

  // input register
  logic        in_valid;
  mode_t       in_mode;
  logic [15:0] in_addr;
  logic        in_is_write;
  logic [7:0]  in_value;

  // result register
  logic             out_valid;
  target_t          out_target;
  logic [PhysW-1:0] out_phys;
  logic             out_wr;
  logic             out_ext_io;
  logic             out_caps;

  logic advance;

  // decode
  bank_sel_t        lo_sel, hi_sel;
  target_t          dec_target;
  logic [PhysW-1:0] dec_phys;
  logic             dec_wr;
  logic [PhysW-1:0] base_exp2, base_exp3, addr_ext;
  logic             cart_bit;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ram_kib       <= RAM_KIB_RESET;
      cart_present  <= 1'b0;
      col80_present <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_RAM_KIB:       ram_kib       <= cfg_data;
        REG_CART_PRESENT:  cart_present  <= cfg_data[0];
        REG_COL80_PRESENT: col80_present <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_mode     <= mode_t'(s_tuser);
      in_addr     <= s_tdata[15:0];
      in_is_write <= s_tdata[16];
      in_value    <= s_tdata[24:17];
    end
  end

  // port writes take effect before the access of the same item is decoded
  always_comb begin
    bank_select_next  = bank_select;
    col80_ram_on_next = col80_ram_on;
    unique case (in_mode)
      MODE_BANK:  bank_select_next = in_value;
      MODE_COL80: if (bank_select[0]) col80_ram_on_next = in_value[0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bank_select  <= BANK_RESET;
      col80_ram_on <= 1'b0;
    end else if (advance) begin
      bank_select  <= bank_select_next;
      col80_ram_on <= col80_ram_on_next;
    end
  end

  always_comb begin
    priority if (!bank_select_next[0]) lo_sel = SEL_CART;
    else if (!bank_select_next[1])     lo_sel = SEL_EXP2;
    else if (bank_select_next[3])      lo_sel = SEL_INT;
    else                               lo_sel = SEL_EXP3;

    priority if (!bank_select_next[2]) hi_sel = SEL_EXP2;
    else if (bank_select_next[4])      hi_sel = SEL_INT;
    else                               hi_sel = SEL_EXP3;
  end

  // expansion bank bases: ram size in bytes less 64 KiB or 128 KiB, mod 2^18
  assign base_exp2 = {ram_kib[7:0], 10'd0} - 18'h10000;
  assign base_exp3 = {ram_kib[7:0], 10'd0} - 18'h20000;
  assign addr_ext  = {2'd0, in_addr};
  assign cart_bit  = in_addr[14] ? bank_select_next[7] : bank_select_next[6];

  always_comb begin
    dec_target = TGT_EMPTY;
    dec_phys   = '0;
    dec_wr     = 1'b0;
    if (!in_addr[15]) begin
      unique case (lo_sel)
        SEL_INT: begin
          dec_target = TGT_ROM;
          dec_phys   = addr_ext;
        end
        SEL_CART: begin
          if (cart_present) begin
            dec_target = TGT_CART;
            dec_phys   = addr_ext;
          end
        end
        SEL_EXP2: begin
          if (ram_kib >= 9'd64) begin
            dec_target = TGT_RAM;
            dec_phys   = base_exp2 + addr_ext;
            dec_wr     = 1'b1;
          end
        end
        SEL_EXP3: begin
          if (ram_kib > 9'd128) begin
            dec_target = TGT_RAM;
            dec_phys   = base_exp3 + addr_ext;
            dec_wr     = 1'b1;
          end
        end
        default: ;
      endcase
    end else if (col80_present && col80_ram_on_next && (in_addr[15:12] == 4'hF)) begin
      // only the lower 2 KiB of the card window is backed
      if (!in_addr[11]) begin
        dec_target = TGT_COL80;
        dec_phys   = {7'd0, in_addr[10:0]};
        dec_wr     = 1'b1;
      end
    end else if ((lo_sel == SEL_CART) && (bank_select_next[7:6] != 2'b11)) begin
      if (cart_present && !cart_bit) begin
        dec_target = TGT_CART;
        dec_phys   = {3'd0, in_addr[14:0]};
      end
    end else begin
      unique case (hi_sel)
        SEL_INT: begin
          if (ram_kib == 9'd16) begin
            // 16 KiB machines only have ram at c000-ffff
            if (in_addr[14]) begin
              dec_target = TGT_RAM;
              dec_phys   = {4'd0, in_addr[13:0]};
              dec_wr     = 1'b1;
            end
          end else begin
            dec_target = TGT_RAM;
            dec_phys   = {3'd0, in_addr[14:0]};
            dec_wr     = 1'b1;
          end
        end
        SEL_EXP2: begin
          if (ram_kib > 9'd64) begin
            dec_target = TGT_RAM;
            dec_phys   = base_exp2 + addr_ext;
            dec_wr     = 1'b1;
          end
        end
        SEL_EXP3: begin
          if (ram_kib > 9'd128) begin
            dec_target = TGT_RAM;
            dec_phys   = base_exp3 + addr_ext;
            dec_wr     = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_target <= dec_target;
      out_phys   <= dec_phys;
      out_wr     <= dec_wr && (in_mode == MODE_ACCESS) && in_is_write;
      out_ext_io <= bank_select_next[0];
      out_caps   <= ~bank_select_next[5];
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_target;
  assign m_tdata  = {3'd0, out_caps, out_ext_io, out_wr, out_phys};

endmodule

// ===== design/mbm_checker.sv =====
// ----------------------------------------------------------------------------
// mbm_checker
// Port-level checks for the memory bank mapper, bound to the top level.
// ----------------------------------------------------------------------------
module mbm_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic [mbm_pkg::InDataW-1:0]   s_tdata,
  input logic [1:0]                    s_tuser,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [mbm_pkg::OutDataW-1:0]  m_tdata,
  input logic [2:0]                    m_tuser,
  input logic                          cfg_valid,
  input logic                          cfg_ready,
  input logic [mbm_pkg::CfgIdxW-1:0]   cfg_index,
  input logic [mbm_pkg::CfgDataW-1:0]  cfg_data
);
  import mbm_pkg::*;

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // no result can appear in the cycle right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result valid right after reset");

  // writes only ever land in ram
  a_wr_target: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[18] |->
      (m_tuser == TGT_RAM) || (m_tuser == TGT_COL80))
    else $error("write allowed to read-only target");

  // empty space always reports offset zero
  a_empty_phys: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == TGT_EMPTY) |-> (m_tdata[17:0] == 18'd0))
    else $error("empty target with nonzero offset");

  // the input only backs up behind a stalled result
  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled without a stalled result");

endmodule

bind memory_bank_mapper_top mbm_checker u_mbm_checker (.*);

// ===== dv/memory_bank_mapper_checker.sv =====
// ----------------------------------------------------------------------------
// memory_bank_mapper_checker
// Watches the access, result and configuration channels of the bank mapper,
// keeps its own copy of the bank-select byte, the card enable and the
// configuration, works out the mapping of every accepted access and compares
// each result transfer field by field against the oldest outstanding mapping.
// ----------------------------------------------------------------------------
module memory_bank_mapper_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  input  logic                          s_tready,
  // [15:0] address, [16] is_write, [24:17] value
  input  logic [mbm_pkg::InDataW-1:0]   s_tdata,
  // [1:0] mode
  input  logic [1:0]                    s_tuser,
  input  logic                          m_tvalid,
  input  logic                          m_tready,
  // [17:0] phys_addr, [18] write_allowed, [19] ext_io_enabled, [20] caps_led_on
  input  logic [mbm_pkg::OutDataW-1:0]  m_tdata,
  // [2:0] target
  input  logic [2:0]                    m_tuser,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [mbm_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [mbm_pkg::CfgDataW-1:0]  cfg_data,
  output int                            fail_count,
  output int                            pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import mbm_pkg::*;

  // what sits behind a region
  typedef enum logic [1:0] {
    SLOT_INT  = 2'd0,
    SLOT_CART = 2'd1,
    SLOT_EXP2 = 2'd2,
    SLOT_EXP3 = 2'd3
  } slot_t;

  typedef struct packed {
    target_t          target;
    logic [PhysW-1:0] phys_addr;
    logic             write_allowed;
    logic             ext_io_enabled;
    logic             caps_led_on;
  } mapping_t;

  logic [8:0] ram_kib_q;
  logic       cart_q;
  logic       col80_fit_q;
  logic [7:0] bank_q;
  logic       col80_on_q;
  mapping_t   mapping_q[$];

  function automatic slot_t low_slot(input logic [7:0] v);
    if (!v[0]) return SLOT_CART;
    if (!v[1]) return SLOT_EXP2;
    return v[3] ? SLOT_INT : SLOT_EXP3;
  endfunction

  function automatic slot_t high_slot(input logic [7:0] v);
    if (!v[2]) return SLOT_EXP2;
    return v[4] ? SLOT_INT : SLOT_EXP3;
  endfunction

  // decode one address against the current bank state
  function automatic mapping_t map_address(input logic [15:0] addr);
    mapping_t    r;
    logic [31:0] a;
    logic [31:0] base;
    logic [31:0] p;
    target_t     tgt;
    logic        wr;
    logic        cart_bit;
    slot_t       lo;
    slot_t       hi;
    a    = {16'd0, addr};
    base = {13'd0, ram_kib_q, 10'd0};
    lo   = low_slot(bank_q);
    hi   = high_slot(bank_q);
    tgt  = TGT_EMPTY;
    p    = 32'd0;
    wr   = 1'b0;
    if (!addr[15]) begin
      case (lo)
        SLOT_INT: begin
          tgt = TGT_ROM;
          p   = a;
        end
        SLOT_CART: begin
          if (cart_q) begin
            tgt = TGT_CART;
            p   = a;
          end
        end
        SLOT_EXP2: begin
          if (ram_kib_q >= 9'd64) begin
            tgt = TGT_RAM;
            p   = base - 32'h10000 + a;
            wr  = 1'b1;
          end
        end
        default: begin
          if (ram_kib_q > 9'd128) begin
            tgt = TGT_RAM;
            p   = base - 32'h20000 + a;
            wr  = 1'b1;
          end
        end
      endcase
    end else if (col80_fit_q && col80_on_q && addr >= 16'hF000) begin
      // upper half of the card window reads as empty
      if (addr < 16'hF800) begin
        tgt = TGT_COL80;
        p   = a - 32'hF000;
        wr  = 1'b1;
      end
    end else if (lo == SLOT_CART && bank_q[7:6] != 2'b11) begin
      cart_bit = addr[14] ? bank_q[7] : bank_q[6];
      if (cart_q && !cart_bit) begin
        tgt = TGT_CART;
        p   = a - 32'h8000;
      end
    end else begin
      case (hi)
        SLOT_INT: begin
          if (ram_kib_q == 9'd16) begin
            if (addr[14]) begin
              tgt = TGT_RAM;
              p   = a - 32'hC000;
              wr  = 1'b1;
            end
          end else begin
            tgt = TGT_RAM;
            p   = a - 32'h8000;
            wr  = 1'b1;
          end
        end
        SLOT_EXP2: begin
          if (ram_kib_q > 9'd64) begin
            tgt = TGT_RAM;
            p   = base - 32'h10000 + a;
            wr  = 1'b1;
          end
        end
        default: begin
          if (ram_kib_q > 9'd128) begin
            tgt = TGT_RAM;
            p   = base - 32'h20000 + a;
            wr  = 1'b1;
          end
        end
      endcase
    end
    r.target         = tgt;
    r.phys_addr      = p[PhysW-1:0];
    r.write_allowed  = wr;
    r.ext_io_enabled = bank_q[0];
    r.caps_led_on    = !bank_q[5];
    return r;
  endfunction

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : monitor
    mapping_t want;
    mode_t    mode;
    if (rst) begin
      ram_kib_q   = RAM_KIB_RESET;
      cart_q      = 1'b0;
      col80_fit_q = 1'b0;
      bank_q      = BANK_RESET;
      col80_on_q  = 1'b0;
      mapping_q.delete();
      fail_count  = 0;
      pending    <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_RAM_KIB:       ram_kib_q   = cfg_data;
          REG_CART_PRESENT:  cart_q      = cfg_data[0];
          REG_COL80_PRESENT: col80_fit_q = cfg_data[0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        mode = mode_t'(s_tuser);
        if (mode == MODE_BANK) begin
          bank_q = s_tdata[24:17];
        end else if (mode == MODE_COL80 && bank_q[0]) begin
          // enable port is dead while the cartridge holds the low bank
          col80_on_q = s_tdata[17];
        end
        want = map_address(s_tdata[15:0]);
        if (mode != MODE_ACCESS || !s_tdata[16]) want.write_allowed = 1'b0;
        mapping_q.push_back(want);
      end
      if (m_tvalid && m_tready) begin
        if (mapping_q.size() == 0) begin
          $error("result transfer with no access outstanding: tuser 0x%0h tdata 0x%0h",
                 m_tuser, m_tdata);
          fail_count++;
        end else begin
          want = mapping_q.pop_front();
          check_field("target", 32'(want.target), 32'(m_tuser));
          check_field("phys_addr", 32'(want.phys_addr), 32'(m_tdata[17:0]));
          check_field("write_allowed", 32'(want.write_allowed), 32'(m_tdata[18]));
          check_field("ext_io_enabled", 32'(want.ext_io_enabled), 32'(m_tdata[19]));
          check_field("caps_led_on", 32'(want.caps_led_on), 32'(m_tdata[20]));
        end
      end
      pending <= mapping_q.size();
    end
  end

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives the bank mapper with a directed run over every mode, bank selection
// and card case, then random accesses and port writes under ten RAM size,
// cartridge and card settings, with random stalls on both streams and one
// long result hold-off. The checker module predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import mbm_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int PhaseCount = 10;
  localparam int PhaseItems = 95;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [InDataW-1:0]    s_tdata = '0;
  logic [1:0]            s_tuser = MODE_ACCESS;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OutDataW-1:0]   m_tdata;
  logic [2:0]            m_tuser;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CfgIdxW-1:0]    cfg_index = REG_RAM_KIB;
  logic [CfgDataW-1:0]   cfg_data = '0;

  int   fail_count;
  int   pending;
  int   cycle_count = 0;
  int   hold_left = 0;
  logic quiet = 1'b0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;

  always #10 clk = ~clk;

  memory_bank_mapper_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  memory_bank_mapper_checker i_checker (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fail_count(fail_count),
    .pending   (pending)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_left <= 80;
      hold_done <= 1'b1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= quiet || ($urandom_range(0, 99) >= 10);
    end
  end

  task automatic send_access(input mode_t mode, input logic [15:0] addr,
                             input logic is_write, input logic [7:0] value);
    while (!quiet && $urandom_range(0, 99) < 10) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {7'd0, value, is_write, addr};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // close a phase: stop offering and wait for every outstanding result
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input logic [8:0] kib, input logic cart, input logic col80);
    cfg_valid <= 1'b1;
    cfg_index <= REG_RAM_KIB;
    cfg_data  <= kib;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    // upper bits of the one-bit registers are don't-care
    cfg_index <= REG_CART_PRESENT;
    cfg_data  <= {8'($urandom), cart};
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= REG_COL80_PRESENT;
    cfg_data  <= {8'($urandom), col80};
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] pick_address();
    logic [15:0] edges[10];
    edges = '{16'h0000, 16'h7FFF, 16'h8000, 16'hBFFF, 16'hC000,
              16'hEFFF, 16'hF000, 16'hF7FF, 16'hF800, 16'hFFFF};
    case ($urandom_range(0, 9))
      0, 1:    return 16'hF000 + 16'($urandom_range(0, 16'hFFF));
      2:       return edges[$urandom_range(0, 9)];
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_bank();
    logic [7:0] picks[10];
    picks = '{8'hFF, 8'hFE, 8'hFD, 8'hF7, 8'hFB, 8'hEF, 8'h3E, 8'h7E, 8'hBE, 8'hDF};
    if ($urandom_range(0, 99) < 35) return picks[$urandom_range(0, 9)];
    return 8'($urandom);
  endfunction

  task automatic send_random();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      send_access(MODE_ACCESS, pick_address(), 1'($urandom), 8'($urandom));
    end else if (pick < 82) begin
      send_access(MODE_BANK, pick_address(), 1'($urandom), pick_bank());
    end else if (pick < 95) begin
      send_access(MODE_COL80, pick_address(), 1'($urandom), 8'($urandom));
    end else begin
      send_access(MODE_UNUSED, pick_address(), 1'($urandom), 8'($urandom));
    end
  endtask

  initial begin : stimulus
    logic [8:0] kib_list[PhaseCount];
    logic       cart_list[PhaseCount];
    logic       col80_list[PhaseCount];
    kib_list   = '{9'd16, 9'd64, 9'd128, 9'd256, 9'd16, 9'd255, 9'd0, 9'd511, 9'd100, 9'd200};
    cart_list  = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
    col80_list = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0};

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_config(9'd256, 1'b1, 1'b1);
    send_access(MODE_ACCESS, 16'h0000, 1'b0, 8'h00);
    send_access(MODE_ACCESS, 16'h7FFF, 1'b1, 8'hFF);
    send_access(MODE_ACCESS, 16'h8000, 1'b1, 8'h00);
    send_access(MODE_ACCESS, 16'hFFFF, 1'b0, 8'hFF);
    send_access(MODE_COL80,  16'hF000, 1'b1, 8'h01);
    send_access(MODE_ACCESS, 16'hF7FF, 1'b1, 8'h00);
    send_access(MODE_ACCESS, 16'hF800, 1'b1, 8'h00);
    send_access(MODE_COL80,  16'hF000, 1'b0, 8'h00);
    // cartridge in the low bank
    send_access(MODE_BANK,   16'h0000, 1'b0, 8'h00);
    send_access(MODE_ACCESS, 16'h8000, 1'b0, 8'h00);
    send_access(MODE_ACCESS, 16'hC000, 1'b1, 8'h00);
    send_access(MODE_COL80,  16'hF000, 1'b0, 8'h01);
    send_access(MODE_BANK,   16'h8000, 1'b0, 8'hC0);
    // expansion banks, low and high
    send_access(MODE_BANK,   16'h0000, 1'b1, 8'hFD);
    send_access(MODE_ACCESS, 16'h0000, 1'b1, 8'h00);
    send_access(MODE_BANK,   16'h7FFF, 1'b0, 8'hF7);
    send_access(MODE_ACCESS, 16'h7FFF, 1'b1, 8'h00);
    send_access(MODE_BANK,   16'hC000, 1'b0, 8'hFB);
    send_access(MODE_BANK,   16'h8000, 1'b0, 8'hEF);
    send_access(MODE_UNUSED, 16'h1234, 1'b1, 8'h5A);
    send_access(MODE_BANK,   16'hBFFF, 1'b1, 8'hDF);
    send_access(MODE_BANK,   16'hFFFF, 1'b0, 8'hFF);
    settle();

    for (int ph = 0; ph < PhaseCount; ph++) begin
      set_config(kib_list[ph], cart_list[ph], col80_list[ph]);
      quiet <= (ph == 3);
      if (ph == 5) hold_req <= 1'b1;
      repeat (PhaseItems) send_random();
      settle();
    end

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
